// ===== rtl/slrg_pkg.sv =====
package slrg_pkg;

	localparam logic [14:0] LEH_A = 15'd16807;
	localparam logic [30:0] LEH_M = 31'h7FFF_FFFF;
	localparam int WARMUP_EXTRA = 7;
	localparam int RECIP_SHIFT = 37;

	localparam logic KIND_RESEED = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WARM_MUL,
		ST_WARM_RED,
		ST_DRAW_MUL,
		ST_DRAW_RED,
		ST_DRAW_SLOT,
		ST_DRAW_READ,
		ST_DRAW_SCALE,
		ST_DRAW_OUT
	} state_t;

	typedef struct packed {
		logic s1_en;
		logic s2_en;
	} scale_ctl_t;

endpackage

// ===== rtl/slrg_ram.sv =====
module slrg_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/slrg_mulmod.sv =====
module slrg_mulmod (
	input  logic        clk,
	input  logic [31:0] x,
	output logic [30:0] res
);

	logic [45:0] prod_q;
	logic [31:0] sum;
	logic [31:0] red;

	always_ff @(posedge clk) begin
		prod_q <= 46'(x) * 46'(slrg_pkg::LEH_A);
	end

	// Fold the product modulo 2^31 - 1; one correction brings it into range.
	always_comb begin
		sum = {17'd0, prod_q[45:31]} + {1'b0, prod_q[30:0]};
		red = (sum >= {1'b0, slrg_pkg::LEH_M}) ? (sum - {1'b0, slrg_pkg::LEH_M}) : sum;
		res = red[30:0];
	end

endmodule

// ===== rtl/slrg_slot.sv =====
module slrg_slot #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                           clk,
	input  logic [30:0]                    last,
	output logic [$clog2(TABLE_DEPTH)-1:0] slot
);

	localparam longint unsigned NDIV = 64'd1 + (64'd2147483646 / 64'(TABLE_DEPTH));
	localparam longint unsigned RECIP = (64'd1 << slrg_pkg::RECIP_SHIFT) / NDIV;
	localparam int RW = $clog2(RECIP + 64'd1);
	localparam int PW = 31 + RW;
	localparam int QW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [RW-1:0] RECIP_W = RW'(RECIP);
	localparam logic [30:0] NDIV_W = 31'(NDIV);

	logic [PW-1:0] prod_s1;
	logic [30:0]   last_s1;
	logic [QW-1:0] est;
	logic [QW-1:0] est_s2;
	logic [30:0]   qm_s2;
	logic [30:0]   last_s2;
	logic [30:0]   rem;
	logic [QW:0]   quo;

	assign est = QW'(prod_s1 >> slrg_pkg::RECIP_SHIFT);

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(last) * PW'(RECIP_W);
		last_s1 <= last;
		est_s2  <= est;
		qm_s2   <= 31'(est) * NDIV_W;
		last_s2 <= last_s1;
	end

	// The reciprocal estimate is low by at most one.
	always_comb begin
		rem = last_s2 - qm_s2;
		quo = {1'b0, est_s2} + (QW + 1)'(rem >= NDIV_W);
		if (quo >= (QW + 1)'(TABLE_DEPTH)) begin
			slot = AW'(TABLE_DEPTH - 1);
		end else begin
			slot = quo[AW-1:0];
		end
	end

endmodule

// ===== rtl/slrg_scale.sv =====
module slrg_scale (
	input  logic                     clk,
	input  slrg_pkg::scale_ctl_t     ctl,
	input  logic [30:0]              v,
	input  logic signed [32:0]       span,
	input  logic [31:0]              lo,
	output logic [31:0]              result
);

	logic [46:0]        pp_lo_s1;
	logic signed [48:0] pp_hi_s1;
	logic [63:0]        p_s2;

	always_ff @(posedge clk) begin
		if (ctl.s1_en) begin
			pp_lo_s1 <= 47'(v) * 47'(span[15:0]);
			pp_hi_s1 <= 49'($signed({1'b0, v})) * 49'($signed(span[32:16]));
		end
		if (ctl.s2_en) begin
			p_s2 <= {pp_hi_s1[47:0], 16'd0} + {17'd0, pp_lo_s1};
		end
	end

	// An arithmetic shift by 31 rounds the quotient toward minus infinity.
	assign result = lo + p_s2[62:31];

endmodule

// ===== rtl/shuffled_lehmer_random_generator_top.sv =====
// Shuffled minimal-standard Lehmer generator with a Bays-Durham shuffle table.
// Input channel s_*: s_tuser selects a reseed (0) or a draw (1); s_tdata carries
// the seed and the Q16.16 range ends. Output channel m_*: one transaction per
// draw with the raw value and its scaled form; a reseed gives no result.
// A draw steps through the multiply and modular fold of the core, then the slot
// estimate, the table RAM read together with the scaling partial products, the
// sum of those products, and the output load with the final add. A new request
// is accepted only once the previous draw has finished.
// A draw that follows a reseed, a reset or a zero output first warms up: it runs
// the same multiply-fold loop while the table RAM is filled.
// Reset clears the core state and the last output, so the first draw warms up;
// the table itself has no reset and needs none.
// The output register holds a result until it is taken. New items are still
// accepted while it waits; a draw that finishes before then waits in its final
// step with s_tready low.
module shuffled_lehmer_random_generator_top #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // seed[31:0], range_low[63:32], range_high[95:64]
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // value[30:0], scaled_value[62:31], zero pad[63]
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + slrg_pkg::WARMUP_EXTRA + 1);

	slrg_pkg::state_t     state_q;
	slrg_pkg::state_t     state_d;
	slrg_pkg::scale_ctl_t scale_ctl;

	logic [CW-1:0]       cnt_q;
	logic [31:0]         core_q;
	logic [30:0]         last_q;
	logic [AW-1:0]       slot_q;
	logic [30:0]         value_q;
	logic [31:0]         lo_q;
	logic signed [32:0]  span_q;
	logic [63:0]         m_tdata_q;
	logic                m_tvalid_q;

	logic [31:0]   seed;
	logic [31:0]   range_low;
	logic [31:0]   range_high;
	logic          accept;
	logic          warm;
	logic          out_free;
	logic          out_load;
	logic [30:0]   step_res;
	logic [AW-1:0] slot;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [30:0]   ram_wdata;
	logic [30:0]   ram_rdata;
	logic [31:0]   scaled;

	assign seed       = s_tdata[31:0];
	assign range_low  = s_tdata[63:32];
	assign range_high = s_tdata[95:64];
	assign accept     = s_tvalid && s_tready;
	assign warm       = ($signed(core_q) <= 32'sd0) || (last_q == 31'd0);
	assign out_free   = !m_tvalid_q || m_tready;
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;

	slrg_mulmod u_mulmod (
		.clk (clk),
		.x   (core_q),
		.res (step_res)
	);

	slrg_slot #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_slot (
		.clk  (clk),
		.last (last_q),
		.slot (slot)
	);

	slrg_ram #(
		.WIDTH(31),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (slot),
		.rdata (ram_rdata)
	);

	slrg_scale u_scale (
		.clk    (clk),
		.ctl    (scale_ctl),
		.v      (ram_rdata),
		.span   (span_q),
		.lo     (lo_q),
		.result (scaled)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			slrg_pkg::ST_IDLE: begin
				if (s_tvalid && (s_tuser == slrg_pkg::KIND_DRAW)) begin
					state_d = warm ? slrg_pkg::ST_WARM_MUL : slrg_pkg::ST_DRAW_MUL;
				end
			end
			slrg_pkg::ST_WARM_MUL: state_d = slrg_pkg::ST_WARM_RED;
			slrg_pkg::ST_WARM_RED: begin
				state_d = (cnt_q == '0) ? slrg_pkg::ST_DRAW_MUL : slrg_pkg::ST_WARM_MUL;
			end
			slrg_pkg::ST_DRAW_MUL:   state_d = slrg_pkg::ST_DRAW_RED;
			slrg_pkg::ST_DRAW_RED:   state_d = slrg_pkg::ST_DRAW_SLOT;
			slrg_pkg::ST_DRAW_SLOT:  state_d = slrg_pkg::ST_DRAW_READ;
			slrg_pkg::ST_DRAW_READ:  state_d = slrg_pkg::ST_DRAW_SCALE;
			slrg_pkg::ST_DRAW_SCALE: state_d = slrg_pkg::ST_DRAW_OUT;
			slrg_pkg::ST_DRAW_OUT: begin
				if (out_free) begin
					state_d = slrg_pkg::ST_IDLE;
				end
			end
			default: state_d = slrg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready        = 1'b0;
		ram_we          = 1'b0;
		ram_waddr       = slot_q;
		ram_wdata       = core_q[30:0];
		scale_ctl.s1_en = 1'b0;
		scale_ctl.s2_en = 1'b0;
		out_load        = 1'b0;
		case (state_q)
			slrg_pkg::ST_IDLE: s_tready = 1'b1;
			slrg_pkg::ST_WARM_RED: begin
				ram_we    = (cnt_q < CW'(TABLE_DEPTH));
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = step_res;
			end
			slrg_pkg::ST_DRAW_READ: begin
				ram_we          = 1'b1;
				scale_ctl.s1_en = 1'b1;
			end
			slrg_pkg::ST_DRAW_SCALE: scale_ctl.s2_en = 1'b1;
			slrg_pkg::ST_DRAW_OUT:   out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= slrg_pkg::ST_IDLE;
			cnt_q      <= '0;
			core_q     <= '0;
			last_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				slrg_pkg::ST_IDLE: begin
					if (accept && (s_tuser == slrg_pkg::KIND_RESEED)) begin
						core_q <= seed[31] ? seed : (~seed + 32'd1);
						last_q <= '0;
					end else if (accept && warm) begin
						core_q <= ($signed(core_q) >= 32'sd0) ? 32'd1 : (~core_q + 32'd1);
						cnt_q  <= CW'(TABLE_DEPTH + slrg_pkg::WARMUP_EXTRA);
					end
				end
				slrg_pkg::ST_WARM_RED: begin
					core_q <= {1'b0, step_res};
					if (cnt_q == '0) begin
						last_q <= step_res;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				slrg_pkg::ST_DRAW_RED:  core_q <= {1'b0, step_res};
				slrg_pkg::ST_DRAW_READ: last_q <= ram_rdata;
				default: ;
			endcase
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (s_tuser == slrg_pkg::KIND_DRAW)) begin
			lo_q   <= range_low;
			span_q <= 33'($signed(range_high)) - 33'($signed(range_low));
		end
		if (state_q == slrg_pkg::ST_DRAW_SLOT) begin
			slot_q <= slot;
		end
		if (state_q == slrg_pkg::ST_DRAW_READ) begin
			value_q <= ram_rdata;
		end
		if (out_load) begin
			m_tdata_q <= {1'b0, scaled, value_q};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == slrg_pkg::ST_WARM_RED || state_q == slrg_pkg::ST_DRAW_READ))
		else $error("Table write outside a fill or replace step.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == slrg_pkg::KIND_DRAW && last_q == 31'd0)
		|=> (state_q == slrg_pkg::ST_WARM_MUL))
		else $error("Draw with a zero last output did not warm up.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == slrg_pkg::ST_WARM_RED && cnt_q == '0) |=> (state_q == slrg_pkg::ST_DRAW_MUL))
		else $error("Warm-up did not hand over to the draw step.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == slrg_pkg::ST_DRAW_OUT))
		else $error("Result appeared without a finished draw.");

endmodule

// ===== tb/slrg_draw_checker.sv =====
`timescale 1ns / 100ps

module slrg_draw_checker
	import slrg_pkg::*;
#(
	parameter int TABLE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [95:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	output int          errors,
	output int          outstanding
);

	localparam longint SCHRAGE_Q = 127773;
	localparam longint SCHRAGE_R = 2836;
	localparam int SLOT_DIV = 1 + (int'(LEH_M) - 1) / TABLE_DEPTH;

	typedef struct packed {
		logic [30:0] value;
		logic [31:0] scaled;
	} draw_result_t;

	logic signed [31:0] core_state;
	logic [30:0] last_value;
	logic [30:0] slots [TABLE_DEPTH];
	draw_result_t expected_draws [$];

	task automatic report_mismatch(input string what);
		if (errors < 200) begin
			$display("%0t ns: mismatch: %s", $time, what);
		end
		errors++;
	endtask

	// Multiplicative step modulo 2^31 - 1, split so that nothing overflows.
	function automatic longint lehmer_advance(input longint x);
		longint k;
		longint t;
		k = x / SCHRAGE_Q;
		t = longint'(LEH_A) * (x - k * SCHRAGE_Q) - SCHRAGE_R * k;
		if (t < 0) begin
			t += longint'(LEH_M);
		end
		return t;
	endfunction

	function automatic logic [31:0] scale_into_range(input logic [30:0] v,
			input logic signed [31:0] lo, input logic signed [31:0] hi);
		longint span;
		longint prod;
		longint q;
		span = longint'(hi) - longint'(lo);
		prod = longint'({33'd0, v}) * span;
		q = prod >>> 31;
		return lo + q[31:0];
	endfunction

	task automatic apply_request(input logic kind, input logic signed [31:0] seed,
			input logic signed [31:0] lo, input logic signed [31:0] hi);
		longint s;
		int slot;
		draw_result_t d;
		s = core_state;
		if (kind == KIND_RESEED) begin
			if (seed < 0) begin
				core_state = seed;
			end else begin
				core_state = -seed;
			end
			last_value = '0;
		end else begin
			if (s <= 0 || last_value == '0) begin
				if (s >= 0) begin
					s = 1;
				end else begin
					s = -s;
				end
				for (int i = TABLE_DEPTH + WARMUP_EXTRA; i >= 0; i--) begin
					s = lehmer_advance(s);
					if (i < TABLE_DEPTH) begin
						slots[i] = s[30:0];
					end
				end
				last_value = slots[0];
			end
			s = lehmer_advance(s);
			core_state = s[31:0];
			slot = last_value / SLOT_DIV;
			if (slot >= TABLE_DEPTH) begin
				slot = TABLE_DEPTH - 1;
			end
			last_value = slots[slot];
			slots[slot] = s[30:0];
			d.value = last_value;
			d.scaled = scale_into_range(last_value, lo, hi);
			expected_draws.push_back(d);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		draw_result_t got;
		draw_result_t want;
		if (!arst_n) begin
			core_state = '0;
			last_value = '0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				slots[i] = '0;
			end
			expected_draws.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.value = m_tdata[30:0];
				got.scaled = m_tdata[62:31];
				if (expected_draws.size() == 0) begin
					report_mismatch($sformatf("result value=%0d with no draw pending",
						got.value));
				end else begin
					want = expected_draws.pop_front();
					if (got.value !== want.value) begin
						report_mismatch($sformatf("value %0d, expected %0d",
							got.value, want.value));
					end
					if (got.scaled !== want.scaled) begin
						report_mismatch($sformatf("scaled_value %h, expected %h",
							got.scaled, want.scaled));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				apply_request(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]);
			end
			outstanding <= expected_draws.size();
		end
	end

endmodule

// ===== tb/shuffled_lehmer_random_generator_top_test.sv =====
`timescale 1ns / 100ps

module shuffled_lehmer_random_generator_top_test;
	import slrg_pkg::*;

	localparam int TABLE_DEPTH = 32;
	localparam int RANDOM_ITEMS = 800;
	localparam int HOLD_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam logic [31:0] MAX_SEED = 32'h7FFF_FFFF;
	localparam logic [31:0] MIN_SEED = 32'h8000_0001;
	localparam logic [31:0] Q16_ONE = 32'h0001_0000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	int          errors;
	int          outstanding;
	bit          idling = 1'b1;
	bit          hold_req = 1'b0;
	int unsigned cycles = 0;

	shuffled_lehmer_random_generator_top #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	slrg_draw_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.errors(errors),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= !idling || $urandom_range(99) >= 21;
			end
		end
	end

	task automatic send_request(input logic kind, input logic [31:0] seed,
			input logic [31:0] lo, input logic [31:0] hi);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {hi, lo, seed};
		do @(posedge clk); while (!s_tready);
		if (idling && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 21);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		logic        kind;
		logic [31:0] seed;
		logic [31:0] lo;
		logic [31:0] hi;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= KIND_DRAW;
		s_tdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(KIND_DRAW, 32'd0, 32'd0, Q16_ONE);
		send_request(KIND_DRAW, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(KIND_DRAW, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(KIND_DRAW, 32'd0, 32'h1234_5678, 32'h1234_5678);
		send_request(KIND_RESEED, 32'd0, 32'd0, 32'd0);
		send_request(KIND_DRAW, 32'd0, 32'hFFFF_0000, Q16_ONE);
		send_request(KIND_RESEED, 32'd1, 32'd0, 32'd0);
		send_request(KIND_DRAW, 32'd0, 32'd0, 32'h7FFF_FFFF);
		send_request(KIND_DRAW, 32'd0, 32'd0, 32'h7FFF_FFFF);
		send_request(KIND_RESEED, 32'hFFFF_FFFF, 32'd0, 32'd0);
		send_request(KIND_DRAW, 32'd0, 32'h8000_0000, 32'd0);
		send_request(KIND_RESEED, MAX_SEED, 32'd0, 32'd0);
		send_request(KIND_DRAW, 32'd0, 32'h0000_0100, Q16_ONE);
		send_request(KIND_DRAW, 32'd0, 32'h0000_0100, Q16_ONE);
		send_request(KIND_RESEED, MIN_SEED, 32'd0, 32'd0);
		send_request(KIND_DRAW, 32'd0, 32'hFFFF_FFFF, 32'd0);
		send_request(KIND_RESEED, MIN_SEED, 32'd0, 32'd0);
		send_request(KIND_DRAW, 32'd0, 32'd0, 32'd0);
		send_request(KIND_RESEED, 32'd5, 32'd0, 32'd0);
		send_request(KIND_RESEED, 32'd12345, 32'd0, 32'd0);
		send_request(KIND_DRAW, 32'd0, 32'hFF00_0000, 32'h00FF_0000);
		send_request(KIND_DRAW, 32'd0, 32'd0, 32'h0064_0000);
		send_request(KIND_DRAW, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		wait_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idling = !(n >= 300 && n < 450);
			if (n == 200) begin
				hold_req = 1'b1;
			end
			if (n == 550) begin
				wait_drained();
			end
			kind = ($urandom_range(99) < 6) ? KIND_RESEED : KIND_DRAW;
			seed = $urandom;
			if (kind == KIND_RESEED && $urandom_range(9) == 0) begin
				case ($urandom_range(4))
					0: seed = 32'd0;
					1: seed = 32'd1;
					2: seed = 32'hFFFF_FFFF;
					3: seed = MAX_SEED;
					default: seed = MIN_SEED;
				endcase
			end
			if (seed == 32'h8000_0000) begin
				seed = MIN_SEED;
			end
			lo = $urandom;
			case ($urandom_range(3))
				0: hi = $urandom;
				1: hi = lo + $urandom_range(32'h00FF_FFFF);
				2: hi = lo - $urandom_range(32'h00FF_FFFF);
				default: begin
					lo = 32'd0;
					hi = 32'h0064_0000;
				end
			endcase
			send_request(kind, seed, lo, hi);
		end

		wait_drained();
		repeat (120) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
